// ----- sv/occupancy_grid_updater_core_macros.svh -----
// ----------------------------------------------------------------------------
// Occupancy grid updater assertion macros
// Concurrent assertion wrappers sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_UPDATER_CORE_MACROS_SVH
`define OCCUPANCY_GRID_UPDATER_CORE_MACROS_SVH

`ifndef SYNTH
`define OGU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OGU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OGU_ASSERT(lbl, prop, msg)
`define OGU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- sv/ogu_pkg.sv -----
// ----------------------------------------------------------------------------
// Occupancy grid updater package
// Field widths, command and register codes, reset values and payload types.
// ----------------------------------------------------------------------------
package ogu_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int DIM_W = 9;    // width_cells / height_cells
  localparam int CS_W  = 12;   // cell_size_mm
  localparam int CFG_W = 12;   // widest register
  localparam int POS_W = 16;
  localparam int IDX_W = 16;
  localparam int VAL_W = 8;

  // 2*pos + n*cs fits 23 bits signed; its magnitude 22 bits
  localparam int NUM_W = 23;
  localparam int MAG_W = 22;
  localparam int DEN_W = 13;   // 2*cs
  localparam int LIN_W = 18;   // row*W + column, W and H below 512

  localparam logic [1:0] CMD_HIT   = 2'd0;
  localparam logic [1:0] CMD_MISS  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_CELL   = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 9'd256;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 9'd256;
  localparam logic [CS_W-1:0]  CELL_RST   = 12'd100;

  localparam logic signed [VAL_W-1:0] CELL_UNKNOWN = -8'sd1;
  localparam logic signed [VAL_W-1:0] CELL_FULL    = 8'sd100;

  typedef struct packed {
    logic [1:0]              command;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [IDX_W-1:0]        read_index;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] cell_value;
    logic                    accepted;
    logic [IDX_W-1:0]        cell_index;
  } out_item_t;

endpackage

// ----- sv/ogu_div.sv -----
// ----------------------------------------------------------------------------
// Occupancy grid divider
// Restoring unsigned divider, one quotient bit per cycle, MAG_W quotient bits.
// ----------------------------------------------------------------------------
module ogu_div
  import ogu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MAG_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [MAG_W-1:0] quot
);

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic             active_r, active_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MAG_W-1:0] quot_r, quot_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;

  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    quot_nxt   = quot_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    rem_sh     = {rem_r, quot_r[MAG_W-1]};
    diff       = rem_sh - {1'b0, den_r};
    if (start) begin
      active_nxt = 1'b1;
      cnt_nxt    = CNT_W'(MAG_W);
      quot_nxt   = num;
      rem_nxt    = '0;
      den_nxt    = den;
    end else if (active_r) begin
      // shift in the next numerator bit, keep the difference if it fits
      if (!diff[DEN_W]) begin
        rem_nxt  = diff[DEN_W-1:0];
        quot_nxt = {quot_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[DEN_W-1:0];
        quot_nxt = {quot_r[MAG_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ----- sv/ogu_grid_mem.sv -----
// ----------------------------------------------------------------------------
// Occupancy grid cell store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ogu_grid_mem
  import ogu_pkg::*;
#(
  parameter int DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF,
  parameter int AW    = $clog2(MAX_WIDTH_DEF * MAX_HEIGHT_DEF)
)
(
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic signed [VAL_W-1:0] wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr,
  output logic signed [VAL_W-1:0] rdata
);

  logic signed [VAL_W-1:0] grid_r [DEPTH];
  logic signed [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      grid_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= grid_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/occupancy_grid_updater_core.sv -----
// ----------------------------------------------------------------------------
// Occupancy grid updater core
// Holds a grid of occupancy cells (-1 unknown, else 0..100 percent) in one
// synchronous memory and applies hit, miss, read and clear commands to it.
//
// Usage: drive in_item and raise start; the command transfers at a rising
// edge with start high and busy low. Each command gives exactly one result
// on out_item, marked by out_valid for one cycle; the receiver cannot stall it.
// States from transfer to the out_valid cycle:
//   hit / miss: PREP, LAUNCH, DIV, INDEX, READ, UPDATE; INDEX ends it off
//     the grid; DIV waits on the 22-step restoring dividers that turn both
//     coordinates into cells in parallel. PREP ends it at zero cell size,
//     width or height. read: PREP, RCHK, READ, UPDATE; RCHK ends it when
//     the index lies past the grid. clear: CLEAR, one cell written per cycle.
// busy drops in the result cycle, so the next command can transfer at the
// edge that ends it: one command at a time, no overlap.
// After reset the same clearing pass runs over all MAX_WIDTH*MAX_HEIGHT cells
// with busy high and no result; configuration writes on cfg_* are taken at
// any time with no wait, but belong in idle periods.
// ----------------------------------------------------------------------------
`include "occupancy_grid_updater_core_macros.svh"

module occupancy_grid_updater_core
  import ogu_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_item,
  output logic             out_valid,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [DIM_W-1:0] W_CAP =
    (MAX_WIDTH  >= (1 << DIM_W)) ? '1 : DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] H_CAP =
    (MAX_HEIGHT >= (1 << DIM_W)) ? '1 : DIM_W'(MAX_HEIGHT);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PREP   = 4'd1;
  localparam logic [3:0] ST_LAUNCH = 4'd2;
  localparam logic [3:0] ST_DIV    = 4'd3;
  localparam logic [3:0] ST_INDEX  = 4'd4;
  localparam logic [3:0] ST_RCHK   = 4'd5;
  localparam logic [3:0] ST_READ   = 4'd6;
  localparam logic [3:0] ST_UPDATE = 4'd7;
  localparam logic [3:0] ST_CLEAR  = 4'd8;

  // configuration
  logic [DIM_W-1:0] width_r, height_r;
  logic [CS_W-1:0]  cell_r;
  logic [DIM_W-1:0] w_eff, h_eff;

  // control and datapath
  logic [3:0]       state_r, state_nxt;
  in_item_t         item_r, item_nxt;
  logic [NUM_W-1:0] numx_r, numx_nxt, numy_r, numy_nxt;
  logic [LIN_W-1:0] area_r, area_nxt;
  logic [LIN_W-1:0] lin_r, lin_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic             clr_emit_r, clr_emit_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic [NUM_W-1:0]  pos2x, pos2y;
  logic [20:0]       prodx, prody;
  logic [MAG_W-1:0]  magx, magy, quotx, quoty;
  logic [DEN_W-1:0]  den;
  logic              div_start, div_done_x, div_done_y, div_done;
  logic              bad_x, bad_y;

  logic                    mem_we, mem_re;
  logic [AW-1:0]           mem_waddr;
  logic signed [VAL_W-1:0] mem_wdata, mem_rdata, cell_new;

  function automatic logic signed [VAL_W-1:0] next_cell(
    input logic [1:0]              cmd,
    input logic signed [VAL_W-1:0] old
  );
    logic signed [10:0] ext;
    logic signed [10:0] t;
    logic signed [10:0] a;
    logic signed [10:0] q;
    ext = 11'(old);
    // hit: (3*old + 100) / 4, miss: old / 4, both truncated toward zero
    t = (cmd == CMD_HIT) ? ((ext <<< 1) + ext + 11'sd100) : ext;
    a = t[10] ? -t : t;
    q = t[10] ? -(a >>> 2) : (a >>> 2);
    if (q > 11'sd100) begin
      q = 11'sd100;
    end else if (q < -11'sd1) begin
      q = -11'sd1;
    end
    return q[VAL_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      cell_r   <= CELL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        CFG_CELL:   cell_r   <= cfg_wdata[CS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign w_eff = (width_r  > W_CAP) ? W_CAP : width_r;
  assign h_eff = (height_r > H_CAP) ? H_CAP : height_r;

  // --------------------------------------------------------------------------
  // coordinate dividers: trunc((2*pos + n*cs) / (2*cs))
  // --------------------------------------------------------------------------
  assign pos2x = {{(NUM_W-POS_W-1){item_r.pos_x[POS_W-1]}}, item_r.pos_x, 1'b0};
  assign pos2y = {{(NUM_W-POS_W-1){item_r.pos_y[POS_W-1]}}, item_r.pos_y, 1'b0};
  assign prodx = w_eff * cell_r;
  assign prody = h_eff * cell_r;

  assign magx = numx_r[NUM_W-1] ? MAG_W'(~numx_r + NUM_W'(1)) : numx_r[MAG_W-1:0];
  assign magy = numy_r[NUM_W-1] ? MAG_W'(~numy_r + NUM_W'(1)) : numy_r[MAG_W-1:0];
  assign den  = {cell_r, 1'b0};
  assign div_start = (state_r == ST_LAUNCH);
  assign div_done  = div_done_x & div_done_y;

  ogu_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (magx),
    .den   (den),
    .done  (div_done_x),
    .quot  (quotx)
  );

  ogu_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (magy),
    .den   (den),
    .done  (div_done_y),
    .quot  (quoty)
  );

  // a negative numerator is only in range when the quotient truncates to zero
  assign bad_x = (numx_r[NUM_W-1] && (quotx != '0)) ||
                 (quotx >= MAG_W'(w_eff));
  assign bad_y = (numy_r[NUM_W-1] && (quoty != '0)) ||
                 (quoty >= MAG_W'(h_eff));

  // --------------------------------------------------------------------------
  // cell store
  // --------------------------------------------------------------------------
  assign cell_new  = next_cell(item_r.command, mem_rdata);
  assign mem_re    = (state_r == ST_READ);
  assign mem_we    = (state_r == ST_CLEAR) ||
                     ((state_r == ST_UPDATE) && (item_r.command != CMD_READ));
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_addr_r : AW'(lin_r);
  assign mem_wdata = (state_r == ST_CLEAR) ? CELL_UNKNOWN : cell_new;

  ogu_grid_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_grid_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (AW'(lin_r)),
    .rdata (mem_rdata)
  );

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    numx_nxt      = numx_r;
    numy_nxt      = numy_r;
    area_nxt      = area_r;
    lin_nxt       = lin_r;
    clr_addr_nxt  = clr_addr_r;
    clr_emit_nxt  = clr_emit_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          if (in_item.command == CMD_CLEAR) begin
            clr_addr_nxt = '0;
            clr_emit_nxt = 1'b1;
            state_nxt    = ST_CLEAR;
          end else begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        area_nxt = w_eff * h_eff;
        numx_nxt = pos2x + NUM_W'(prodx);
        numy_nxt = pos2y + NUM_W'(prody);
        if (item_r.command == CMD_READ) begin
          state_nxt = ST_RCHK;
        end else if ((cell_r == '0) || (w_eff == '0) || (h_eff == '0)) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '0;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_INDEX;
        end
      end
      ST_INDEX: begin
        lin_nxt = LIN_W'(quoty[DIM_W-1:0]) * LIN_W'(w_eff) + LIN_W'(quotx[DIM_W-1:0]);
        if (bad_x || bad_y) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '0;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_RCHK: begin
        lin_nxt = LIN_W'(item_r.read_index);
        if (LIN_W'(item_r.read_index) >= area_r) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.cell_value = '0;
          out_item_nxt.accepted   = 1'b0;
          out_item_nxt.cell_index = item_r.read_index;
          state_nxt               = ST_IDLE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        out_valid_nxt           = 1'b1;
        out_item_nxt.cell_value = (item_r.command == CMD_READ) ? mem_rdata : cell_new;
        out_item_nxt.accepted   = 1'b1;
        out_item_nxt.cell_index = lin_r[IDX_W-1:0];
        state_nxt               = ST_IDLE;
      end
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          // the pass after reset ends silently
          if (clr_emit_r) begin
            out_valid_nxt           = 1'b1;
            out_item_nxt.cell_value = CELL_UNKNOWN;
            out_item_nxt.accepted   = 1'b1;
            out_item_nxt.cell_index = '0;
          end
          clr_emit_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      clr_emit_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_emit_r  <= clr_emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    numx_r     <= numx_nxt;
    numy_r     <= numy_nxt;
    area_r     <= area_nxt;
    lin_r      <= lin_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `OGU_ASSERT_NEXT(a_single_result, out_valid_r, !out_valid_r, "result strobe longer than one cycle")
  `OGU_ASSERT_NEXT(a_transfer_busy, start && !busy, busy, "busy not raised after a transfer")
  `OGU_ASSERT(a_write_state, mem_we |-> (state_r == ST_UPDATE || state_r == ST_CLEAR), "cell write outside update or clear")
  `OGU_ASSERT(a_div_state, div_done |-> (state_r == ST_DIV), "divider finished outside divide state")
  `OGU_ASSERT(a_read_range, (state_r == ST_READ) |-> (lin_r < area_r), "cell read beyond the grid")

endmodule
